// ===== src/madt_pkg.sv =====
// shared types and constants of the madt entry parser
package madt_pkg;

    // item kinds carried on the slave-side tuser
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_BYTE  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    // parse phase codes
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_RECORDS = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;
    localparam logic [1:0] PH_BAD     = 2'd3;

    // header layout
    localparam int unsigned LEN_OFF   = 4;
    localparam int unsigned LAPIC_OFF = 36;
    localparam int unsigned REC_OFF   = 44;

    // record types
    localparam logic [7:0] REC_LAPIC    = 8'd0;
    localparam logic [7:0] REC_IOAPIC   = 8'd1;
    localparam logic [7:0] REC_OVERRIDE = 8'd2;

    typedef struct packed {
        logic [31:0] lapic;
        logic [31:0] ioapic;
        logic        bsp_seen;
        logic [7:0]  bsp_value;
        logic [1:0]  phase;
    } t_parse_status;

    typedef struct packed {
        logic        valid;
        logic [7:0]  irq;
        logic [31:0] gsi;
        logic [15:0] flags;
    } t_ovr_append;

    typedef struct packed {
        logic        hit;
        logic [31:0] gsi;
        logic [15:0] flags;
    } t_ovr_result;

endpackage

// ===== src/madt_byte_fsm.sv =====
// byte-serial walker over the madt header and its type/length records
module madt_byte_fsm (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic [1:0]             i_mode,
    input  logic [7:0]             i_byte,
    output madt_pkg::t_parse_status o_status,
    output madt_pkg::t_ovr_append  o_append,
    output logic                   o_clear
);
    import madt_pkg::*;

    logic [31:0] r_offset, n_offset;
    logic [31:0] r_tlen, n_tlen;
    logic [1:0]  r_phase, n_phase;
    logic [31:0] r_lapic, n_lapic;
    logic [31:0] r_ioapic, n_ioapic;
    logic        r_bsp_seen, n_bsp_seen;
    logic [7:0]  r_bsp_value, n_bsp_value;
    logic [7:0]  r_rtype, n_rtype;
    logic [7:0]  r_rlen, n_rlen;
    logic [7:0]  r_rpos, n_rpos;
    logic [7:0]  r_byte3, n_byte3;
    logic [31:0] r_word, n_word;
    logic [15:0] r_half, n_half;

    logic [31:0] w_lane;
    logic [15:0] w_half_lane;
    logic        w_bad;
    logic        w_rec_end;

    always_comb begin
        n_offset    = r_offset;
        n_tlen      = r_tlen;
        n_phase     = r_phase;
        n_lapic     = r_lapic;
        n_ioapic    = r_ioapic;
        n_bsp_seen  = r_bsp_seen;
        n_bsp_value = r_bsp_value;
        n_rtype     = r_rtype;
        n_rlen      = r_rlen;
        n_rpos      = r_rpos;
        n_byte3     = r_byte3;
        n_word      = r_word;
        n_half      = r_half;
        o_append    = '0;
        o_clear     = 1'b0;
        w_lane      = '0;
        w_half_lane = '0;
        w_bad       = 1'b0;
        w_rec_end   = 1'b0;

        if (i_step) begin
            case (i_mode)
                MODE_START: begin
                    o_clear     = 1'b1;
                    n_offset    = '0;
                    n_tlen      = '0;
                    n_phase     = PH_HEADER;
                    n_lapic     = '0;
                    n_ioapic    = '0;
                    n_bsp_seen  = 1'b0;
                    n_bsp_value = '0;
                    n_rtype     = '0;
                    n_rlen      = '0;
                    n_rpos      = '0;
                    n_byte3     = '0;
                    n_word      = '0;
                    n_half      = '0;
                end
                MODE_BYTE: begin
                    if (r_phase == PH_HEADER) begin
                        // both header words sit on 4-byte aligned offsets
                        w_lane = {24'd0, i_byte} << {r_offset[1:0], 3'b000};
                        if (r_offset inside {[LEN_OFF:LEN_OFF+3]}) begin
                            n_tlen = r_tlen | w_lane;
                        end else if (r_offset inside {[LAPIC_OFF:LAPIC_OFF+3]}) begin
                            n_lapic = r_lapic | w_lane;
                        end
                        n_offset = r_offset + 32'd1;
                        if (n_offset >= REC_OFF) begin
                            w_rec_end = 1'b1;
                        end
                    end else if (r_phase == PH_RECORDS) begin
                        n_offset = r_offset + 32'd1;
                        w_lane = {24'd0, i_byte} << {r_rpos[1:0], 3'b000};
                        w_half_lane = {8'd0, i_byte} << {r_rpos[0], 3'b000};
                        if (r_rpos == 8'd0) begin
                            n_rtype = i_byte;
                        end else if (r_rpos == 8'd1) begin
                            n_rlen = i_byte;
                            // too short, or reaching past the table end
                            w_bad = (i_byte < 8'd2) ||
                                    (({2'd0, r_offset} - 34'd1 + {26'd0, i_byte}) >
                                     {2'd0, r_tlen});
                        end else if (r_rpos == 8'd3) begin
                            n_byte3 = i_byte;
                        end else if (r_rpos inside {[8'd4:8'd7]}) begin
                            n_word = r_word | w_lane;
                        end else if (r_rpos inside {[8'd8:8'd9]}) begin
                            n_half = r_half | w_half_lane;
                        end

                        if (w_bad) begin
                            n_phase = PH_BAD;
                        end else if ((({1'b0, r_rpos} + 9'd1) >= {1'b0, n_rlen}) &&
                                     (r_rpos != 8'd0)) begin
                            // last byte of the record: use it, then open the next
                            w_rec_end = 1'b1;
                            case (r_rtype)
                                REC_LAPIC: begin
                                    if (n_word[0] && !r_bsp_seen) begin
                                        n_bsp_seen  = 1'b1;
                                        n_bsp_value = n_byte3;
                                    end
                                end
                                REC_IOAPIC: begin
                                    if (r_ioapic == '0) begin
                                        n_ioapic = n_word;
                                    end
                                end
                                REC_OVERRIDE: begin
                                    o_append.valid = 1'b1;
                                    o_append.irq   = n_byte3;
                                    o_append.gsi   = n_word;
                                    o_append.flags = n_half;
                                end
                                default: begin
                                end
                            endcase
                        end else begin
                            n_rpos = r_rpos + 8'd1;
                        end
                    end
                end
                default: begin
                end
            endcase

            if (w_rec_end) begin
                n_rpos  = '0;
                n_rtype = '0;
                n_rlen  = '0;
                n_byte3 = '0;
                n_word  = '0;
                n_half  = '0;
                if (({2'd0, n_offset} + 34'd2) > {2'd0, r_tlen}) begin
                    n_phase = PH_DONE;
                end else begin
                    n_phase = PH_RECORDS;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= '0;
            r_tlen      <= '0;
            r_phase     <= PH_HEADER;
            r_lapic     <= '0;
            r_ioapic    <= '0;
            r_bsp_seen  <= 1'b0;
            r_bsp_value <= '0;
            r_rtype     <= '0;
            r_rlen      <= '0;
            r_rpos      <= '0;
            r_byte3     <= '0;
            r_word      <= '0;
            r_half      <= '0;
        end else begin
            r_offset    <= n_offset;
            r_tlen      <= n_tlen;
            r_phase     <= n_phase;
            r_lapic     <= n_lapic;
            r_ioapic    <= n_ioapic;
            r_bsp_seen  <= n_bsp_seen;
            r_bsp_value <= n_bsp_value;
            r_rtype     <= n_rtype;
            r_rlen      <= n_rlen;
            r_rpos      <= n_rpos;
            r_byte3     <= n_byte3;
            r_word      <= n_word;
            r_half      <= n_half;
        end
    end

    assign o_status.lapic     = r_lapic;
    assign o_status.ioapic    = r_ioapic;
    assign o_status.bsp_seen  = r_bsp_seen;
    assign o_status.bsp_value = r_bsp_value;
    assign o_status.phase     = r_phase;

endmodule

// ===== src/madt_ovr_table.sv =====
// interrupt override store with parallel first-match lookup
module madt_ovr_table #(
    parameter int MAX_OVERRIDES = 16,
    parameter int CNT_W         = $clog2(MAX_OVERRIDES + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_clear,
    input  madt_pkg::t_ovr_append i_append,
    input  logic                  i_query,
    input  logic [31:0]           i_irq,
    output logic [CNT_W-1:0]      o_count,
    output madt_pkg::t_ovr_result o_result
);
    import madt_pkg::*;

    localparam int IDX_W = (MAX_OVERRIDES > 1) ? $clog2(MAX_OVERRIDES) : 1;

    logic [7:0]  r_irq   [MAX_OVERRIDES];
    logic [31:0] r_gsi   [MAX_OVERRIDES];
    logic [15:0] r_flags [MAX_OVERRIDES];
    logic [CNT_W-1:0] r_count;

    logic        w_full;
    logic        w_hit;
    logic [31:0] w_gsi;
    logic [15:0] w_flags;
    t_ovr_result r_result, n_result;

    assign w_full = (r_count >= CNT_W'(MAX_OVERRIDES));

    always_ff @(posedge i_clk) begin
        if (i_append.valid && !w_full) begin
            r_irq[r_count[IDX_W-1:0]]   <= i_append.irq;
            r_gsi[r_count[IDX_W-1:0]]   <= i_append.gsi;
            r_flags[r_count[IDX_W-1:0]] <= i_append.flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_count <= '0;
        end else if (i_append.valid && !w_full) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // walk from the top so the lowest matching entry wins
    always_comb begin
        w_hit   = 1'b0;
        w_gsi   = i_irq;
        w_flags = '0;
        for (int i = MAX_OVERRIDES - 1; i >= 0; i--) begin
            if ((CNT_W'(i) < r_count) && (i_irq[31:8] == '0) &&
                (r_irq[i] == i_irq[7:0])) begin
                w_hit   = 1'b1;
                w_gsi   = r_gsi[i];
                w_flags = r_flags[i];
            end
        end
    end

    always_comb begin
        n_result = '0;
        if (i_query) begin
            n_result.hit   = w_hit;
            n_result.gsi   = w_gsi;
            n_result.flags = w_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_result <= n_result;
        end
    end

    assign o_count  = r_count;
    assign o_result = r_result;

endmodule

// ===== src/madt_entry_parser.sv =====
// top level of the madt entry parser: input stage, record walker, override table
//
// One item per clock in steady state, while the result side takes each result.
// An item sits in an input register; with the output free the header/record byte
// walker and the override compare (one comparator per table entry) run from
// that register and the new state and lookup result are registered together,
// which is what the result word shows. The input register takes a new transfer
// whenever the item it holds moves on, so a waiting result does not stop intake
// until both stages are full. Item kind on tuser: 0 clears everything and starts
// a new table, 1 feeds the next table byte, 2 looks up an irq, 3 only reports.
// Override entries are not cleared; only entries below the stored count are ever
// compared, so no clearing pass is needed after reset.
module madt_entry_parser #(
    parameter int MAX_OVERRIDES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [39:0]          i_s_tdata,   // data_byte[7:0], irq[39:8]
    input  logic [1:0]           i_s_tuser,   // mode[1:0]
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // lapic_base, ioapic_base, apic_ready, bsp_found, bsp_id, override_count,
    // parse_phase, gsi, override_hit, override_flags, zero fill
    output logic [((125 + $clog2(MAX_OVERRIDES + 1) + 7) / 8) * 8 - 1:0] o_m_tdata
);
    import madt_pkg::*;

    localparam int CNT_W   = $clog2(MAX_OVERRIDES + 1);
    localparam int RAW_W   = 125 + CNT_W;
    localparam int OUT_W   = ((RAW_W + 7) / 8) * 8;

    // input stage
    logic        r_in_valid;
    logic [1:0]  r_in_mode;
    logic [7:0]  r_in_byte;
    logic [31:0] r_in_irq;
    logic        r_out_valid;

    logic        w_s_xfer;
    logic        w_out_free;
    logic        w_step;

    t_parse_status    w_status;
    t_ovr_append      w_append;
    logic             w_clear;
    logic [CNT_W-1:0] w_count;
    t_ovr_result      w_result;
    logic             w_ready;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_step     = r_in_valid && w_out_free;
    assign o_s_tready = !r_in_valid || w_out_free;
    assign w_s_xfer   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= w_s_xfer || (r_in_valid && !w_step);
            r_out_valid <= w_step || (r_out_valid && !i_m_tready);
        end
    end

    // payload of the input stage, loaded on every slave-side transfer
    always_ff @(posedge i_clk) begin
        if (w_s_xfer) begin
            r_in_mode <= i_s_tuser;
            r_in_byte <= i_s_tdata[7:0];
            r_in_irq  <= i_s_tdata[39:8];
        end
    end

    madt_byte_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_mode   (r_in_mode),
        .i_byte   (r_in_byte),
        .o_status (w_status),
        .o_append (w_append),
        .o_clear  (w_clear)
    );

    madt_ovr_table #(
        .MAX_OVERRIDES (MAX_OVERRIDES),
        .CNT_W         (CNT_W)
    ) u_ovr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_clear  (w_clear),
        .i_append (w_append),
        .i_query  (r_in_mode == MODE_QUERY),
        .i_irq    (r_in_irq),
        .o_count  (w_count),
        .o_result (w_result)
    );

    // state only moves when a result is loaded, so it stays put while a result waits
    assign w_ready    = (w_status.lapic != '0) && (w_status.ioapic != '0);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {
        {(OUT_W - RAW_W){1'b0}},
        w_result.flags,
        w_result.hit,
        w_result.gsi,
        w_status.phase,
        w_count,
        (w_status.bsp_seen ? w_status.bsp_value : 8'd0),
        w_status.bsp_seen,
        w_ready,
        (w_ready ? w_status.ioapic : 32'd0),
        w_status.lapic
    };

endmodule

// ===== src/madt_checker.sv =====
// port-level checks of the madt entry parser and their bind
module madt_checker #(
    parameter int MAX_OVERRIDES = 16
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [((125 + $clog2(MAX_OVERRIDES + 1) + 7) / 8) * 8 - 1:0] o_m_tdata
);
    import madt_pkg::*;

    localparam int CNT_W   = $clog2(MAX_OVERRIDES + 1);
    localparam int BSP_LO  = 66;
    localparam int CNT_LO  = 74;
    localparam int PH_LO   = CNT_LO + CNT_W;
    localparam int HIT_BIT = PH_LO + 2 + 32;
    localparam int FLG_LO  = HIT_BIT + 1;

    logic [31:0]      w_lapic;
    logic [31:0]      w_ioapic;
    logic             w_ready;
    logic             w_bsp_found;
    logic [7:0]       w_bsp_id;
    logic [CNT_W-1:0] w_count;
    logic [1:0]       w_phase;
    logic             w_hit;
    logic [15:0]      w_flags;

    assign w_lapic     = o_m_tdata[31:0];
    assign w_ioapic    = o_m_tdata[63:32];
    assign w_ready     = o_m_tdata[64];
    assign w_bsp_found = o_m_tdata[65];
    assign w_bsp_id    = o_m_tdata[BSP_LO +: 8];
    assign w_count     = o_m_tdata[CNT_LO +: CNT_W];
    assign w_phase     = o_m_tdata[PH_LO +: 2];
    assign w_hit       = o_m_tdata[HIT_BIT];
    assign w_flags     = o_m_tdata[FLG_LO +: 16];

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    a_ready_matches_bases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_ready == ((w_lapic != '0) && (w_ioapic != '0))))
        else $error("apic_ready disagrees with the bases");

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_hit || (w_flags == '0)) && (w_bsp_found || (w_bsp_id == '0)))
        else $error("flags or bsp id set without their qualifier");

    a_header_has_no_records: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (w_phase == PH_HEADER) |->
            (w_count == '0) && !w_bsp_found && (w_ioapic == '0))
        else $error("record results present while still in the header");

endmodule

bind madt_entry_parser madt_checker #(
    .MAX_OVERRIDES (MAX_OVERRIDES)
) u_madt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ===== tb/madt_entry_parser_tb.sv =====
// self-checking stream testbench of the madt entry parser with a byte-level predictor
module madt_entry_parser_tb;
    import madt_pkg::*;

    // kind 3 moves no state, it only reports
    localparam logic [1:0] MODE_NOP = 2'd3;
    localparam int OVR_CAP     = 16;
    localparam int STALL_LIMIT = 500;
    localparam int ITEM_TARGET = 1000;
    localparam int CALM_FROM   = 900;

    // result word, lowest field in the lowest bits
    typedef struct packed {
        logic [15:0] flags;
        logic        hit;
        logic [31:0] gsi;
        logic [1:0]  phase;
        logic [4:0]  count;
        logic [7:0]  bsp_id;
        logic        bsp_found;
        logic        ready;
        logic [31:0] ioapic;
        logic [31:0] lapic;
    } t_madt_status;

    // one directed row: an item repeated reps times, optionally with a hand-typed result
    typedef struct {
        logic [1:0]   kind;
        logic [7:0]   data;
        logic [31:0]  irq;
        int           reps;
        bit           typed;
        t_madt_status want;
    } t_stim_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [39:0]  s_tdata = '0;     // data_byte[7:0], irq[39:8]
    logic [1:0]   s_tuser = MODE_NOP; // mode[1:0]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;          // status fields from lapic_base up, zero fill on top

    madt_entry_parser uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // walker state mirrored by the predictor
    // ------------------------------------------------------------------
    logic [31:0] rd_offset;
    logic [31:0] tbl_len;
    logic [1:0]  walk_phase;
    logic [31:0] lapic_q;
    logic [31:0] ioapic_q;
    logic        bsp_seen_q;
    logic [7:0]  bsp_id_q;
    logic [7:0]  rec_type;
    logic [7:0]  rec_len;
    logic [7:0]  rec_pos;
    logic [7:0]  rec_id;
    logic [31:0] rec_word;
    logic [15:0] rec_half;
    logic [7:0]  ovr_irq_tbl [OVR_CAP];
    logic [31:0] ovr_gsi_tbl [OVR_CAP];
    logic [15:0] ovr_flags_tbl [OVR_CAP];
    logic [4:0]  ovr_num;

    t_madt_status pending_status [$];  // results owed by the block, oldest first
    t_stim_row    stim_rows [$];
    logic [7:0]   table_irqs [$];      // irqs of the override records of the current table
    t_madt_status seen_status;
    int           mismatches = 0;
    int           live_items = 0;
    int           idle_run = 0;
    bit           calm = 1'b0;         // no idling on either side near the end

    function automatic void clear_walker();
        rd_offset  = '0;
        tbl_len    = '0;
        walk_phase = PH_HEADER;
        lapic_q    = '0;
        ioapic_q   = '0;
        bsp_seen_q = 1'b0;
        bsp_id_q   = '0;
        rec_type   = '0;
        rec_len    = '0;
        rec_pos    = '0;
        rec_id     = '0;
        rec_word   = '0;
        rec_half   = '0;
        ovr_num    = '0;
    endfunction

    // record boundary: fewer than two bytes left means a normal end
    function automatic void open_record();
        rec_pos  = '0;
        rec_type = '0;
        rec_len  = '0;
        rec_id   = '0;
        rec_word = '0;
        rec_half = '0;
        walk_phase = (33'(rd_offset) + 33'd2 > 33'(tbl_len)) ? PH_DONE : PH_RECORDS;
    endfunction

    function automatic void close_record();
        case (rec_type)
            REC_LAPIC: begin
                if (rec_word[0] && !bsp_seen_q) begin
                    bsp_seen_q = 1'b1;
                    bsp_id_q   = rec_id;
                end
            end
            REC_IOAPIC: begin
                if (ioapic_q == '0)
                    ioapic_q = rec_word;
            end
            REC_OVERRIDE: begin
                // table full: the record is dropped
                if (ovr_num < OVR_CAP) begin
                    ovr_irq_tbl[ovr_num[3:0]]   = rec_id;
                    ovr_gsi_tbl[ovr_num[3:0]]   = rec_word;
                    ovr_flags_tbl[ovr_num[3:0]] = rec_half;
                    ovr_num++;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void feed_byte(logic [7:0] b);
        logic [31:0] off;
        off = rd_offset;
        if (walk_phase == PH_HEADER) begin
            // all header bytes are taken whatever the table length says
            if (off >= LEN_OFF && off < LEN_OFF + 4)
                tbl_len |= 32'(b) << (8 * (off - LEN_OFF));
            else if (off >= LAPIC_OFF && off < LAPIC_OFF + 4)
                lapic_q |= 32'(b) << (8 * (off - LAPIC_OFF));
            rd_offset = off + 1;
            if (rd_offset >= REC_OFF)
                open_record();
            return;
        end
        // after a normal end or a bad record the bytes fall on the floor
        if (walk_phase != PH_RECORDS)
            return;
        rd_offset = off + 1;
        if (rec_pos == 8'd0) begin
            rec_type = b;
        end else if (rec_pos == 8'd1) begin
            rec_len = b;
            // too short, or running past the table length
            if (b < 8'd2 || 33'(off) - 33'd1 + 33'(b) > 33'(tbl_len)) begin
                walk_phase = PH_BAD;
                return;
            end
        end else if (rec_pos == 8'd3) begin
            rec_id = b;
        end else if (rec_pos >= 8'd4 && rec_pos < 8'd8) begin
            rec_word |= 32'(b) << (8 * (rec_pos - 8'd4));
        end else if (rec_pos == 8'd8 || rec_pos == 8'd9) begin
            rec_half |= 16'(b) << (8 * (rec_pos - 8'd8));
        end
        // fields past the record end were never filled, so they stay zero
        if (int'(rec_pos) + 1 >= int'(rec_len) && rec_pos >= 8'd1) begin
            close_record();
            open_record();
        end else begin
            rec_pos = rec_pos + 8'd1;
        end
    endfunction

    function automatic t_madt_status apply_item(logic [1:0] kind, logic [7:0] data,
                                                logic [31:0] irq);
        t_madt_status r;
        logic         ready;
        r = '0;
        case (kind)
            MODE_START: clear_walker();
            MODE_BYTE:  feed_byte(data);
            MODE_QUERY: begin
                // first matching override wins; stored irqs are 8 bits wide
                r.gsi = irq;
                for (int i = 0; i < ovr_num; i++) begin
                    if ({24'd0, ovr_irq_tbl[i]} == irq) begin
                        r.gsi   = ovr_gsi_tbl[i];
                        r.flags = ovr_flags_tbl[i];
                        r.hit   = 1'b1;
                        break;
                    end
                end
            end
            default: ;
        endcase
        ready       = (lapic_q != '0) && (ioapic_q != '0);
        r.lapic     = lapic_q;
        r.ioapic    = ready ? ioapic_q : '0;
        r.ready     = ready;
        r.bsp_found = bsp_seen_q;
        r.bsp_id    = bsp_seen_q ? bsp_id_q : '0;
        r.count     = ovr_num;
        r.phase     = walk_phase;
        return r;
    endfunction

    function automatic t_madt_status make_status(logic [31:0] lapic, logic [4:0] count,
                                                 logic [1:0] phase, logic [31:0] gsi,
                                                 logic hit, logic [15:0] flags);
        t_madt_status r;
        r       = '0;
        r.lapic = lapic;
        r.count = count;
        r.phase = phase;
        r.gsi   = gsi;
        r.hit   = hit;
        r.flags = flags;
        return r;
    endfunction

    function automatic void add_row(logic [1:0] kind, logic [7:0] data, logic [31:0] irq,
                                    int reps, bit typed = 1'b0, t_madt_status want = '0);
        stim_rows.push_back('{kind, data, irq, reps, typed, want});
    endfunction

    function automatic logic [31:0] pick_irq();
        case ($urandom_range(0, 4))
            0, 1: begin
                if (table_irqs.size() != 0)
                    return 32'(table_irqs[$urandom_range(0, table_irqs.size() - 1)]);
                return $urandom_range(0, 15);
            end
            2:       return $urandom_range(0, 20);
            3:       return $urandom;
            default: return $urandom | 32'h0000_0100;  // never matches a stored irq
        endcase
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t mismatch %s: expected %h, actual %h", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    task automatic check_status(t_madt_status want, t_madt_status got);
        check_field("lapic_base", want.lapic, got.lapic);
        check_field("ioapic_base", want.ioapic, got.ioapic);
        check_field("apic_ready", 32'(want.ready), 32'(got.ready));
        check_field("bsp_found", 32'(want.bsp_found), 32'(got.bsp_found));
        check_field("bsp_id", 32'(want.bsp_id), 32'(got.bsp_id));
        check_field("override_count", 32'(want.count), 32'(got.count));
        check_field("parse_phase", 32'(want.phase), 32'(got.phase));
        check_field("gsi", want.gsi, got.gsi);
        check_field("override_hit", 32'(want.hit), 32'(got.hit));
        check_field("override_flags", 32'(want.flags), 32'(got.flags));
    endtask

    // result side, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            seen_status = m_tdata[129:0];
            if (pending_status.size() == 0) begin
                $display("%0t mismatch result: expected none, actual %h", $time, seen_status);
                mismatches++;
            end else begin
                check_status(pending_status.pop_front(), seen_status);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run >= STALL_LIMIT) begin
            $display("%0t no transfer for %0d cycles", $time, idle_run);
            $display("madt_entry_parser regression: fail");
            $finish;
        end
    end

    // result-side backpressure: stall bursts of random length, ready stretches that
    // are sometimes long, and none at all near the end
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (calm) begin
                m_tready = 1'b1;
            end else if (hold_left > 0) begin
                hold_left--;
            end else if ($urandom_range(0, 2) == 0) begin
                m_tready  = 1'b0;
                hold_left = $urandom_range(0, 9);
            end else begin
                m_tready  = 1'b1;
                hold_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                        : $urandom_range(0, 9);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // one input transfer; starts and ends at a falling edge
    task automatic send_item(logic [1:0] kind, logic [7:0] data, logic [31:0] irq,
                             bit typed = 1'b0, t_madt_status want = '0);
        t_madt_status predicted;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {irq, data};
        do @(posedge i_clk); while (!s_tready);
        predicted = apply_item(kind, data, irq);
        pending_status.push_back(typed ? want : predicted);
        live_items++;
        calm = (live_items >= CALM_FROM);
        @(negedge i_clk);
    endtask

    task automatic send_aside();
        if ($urandom_range(0, 3) == 0)
            send_item(MODE_NOP, 8'($urandom), $urandom);
        else
            send_item(MODE_QUERY, 8'($urandom), pick_irq());
    endtask

    // one well-formed table with random content, sometimes damaged
    task automatic run_table();
        logic [7:0]  hdr [44];
        logic [7:0]  body [$];
        logic [7:0]  rtype;
        logic [31:0] tlen;
        logic [31:0] lapic;
        int          nrec;
        int          rlen;
        int          rs;
        int          total;
        bit          crowded;
        table_irqs.delete();
        crowded = ($urandom_range(0, 4) == 0);  // many overrides, often enough to fill the table
        nrec = crowded ? $urandom_range(17, 19) : $urandom_range(0, 8);
        for (int k = 0; k < nrec; k++) begin
            if (!crowded && $urandom_range(0, 11) == 0) begin
                // record length below two
                body.push_back(8'($urandom));
                body.push_back(8'($urandom_range(0, 1)));
                body.push_back(8'($urandom));
                continue;
            end
            case (crowded ? ($urandom_range(0, 5) == 0 ? 0 : 2) : $urandom_range(0, 3))
                0: begin rtype = REC_LAPIC;    rlen = 8;  end
                1: begin rtype = REC_IOAPIC;   rlen = 12; end
                2: begin rtype = REC_OVERRIDE; rlen = 10; end
                default: begin
                    rtype = 8'($urandom_range(3, 255));
                    rlen  = $urandom_range(2, 16);
                end
            endcase
            // short and long variants of the known records
            if ($urandom_range(0, 5) == 0)
                rlen = $urandom_range(2, 12);
            rs = body.size();
            body.push_back(rtype);
            body.push_back(8'(rlen));
            for (int p = 2; p < rlen; p++)
                body.push_back(8'($urandom));
            if (rtype == REC_OVERRIDE && rlen > 3) begin
                if ($urandom_range(0, 3) != 0)
                    body[rs + 3] = 8'($urandom_range(0, 15));
                table_irqs.push_back(body[rs + 3]);
            end else if (rtype == REC_LAPIC && rlen > 4 && $urandom_range(0, 3) == 0) begin
                body[rs + 4] = body[rs + 4] & 8'hFE;  // disabled processor
            end else if (rtype == REC_IOAPIC && rlen > 7 && $urandom_range(0, 4) == 0) begin
                for (int p = 4; p < 8; p++)
                    body[rs + p] = 8'h00;
            end
        end
        total = REC_OFF + body.size();
        case ($urandom_range(0, 9))
            6:       tlen = total + 1;                         // one spare byte
            7:       tlen = (total > REC_OFF + 2) ? total - $urandom_range(1, 4) : total;
            8:       tlen = $urandom_range(0, REC_OFF - 1);    // shorter than the header
            9:       tlen = $urandom_range(0, 1) ? total + $urandom_range(2, 8) : $urandom;
            default: tlen = total;
        endcase
        lapic = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom;
        for (int i = 0; i < REC_OFF; i++)
            hdr[i] = 8'($urandom);
        for (int i = 0; i < 4; i++) begin
            hdr[LEN_OFF + i]   = tlen[8 * i +: 8];
            hdr[LAPIC_OFF + i] = lapic[8 * i +: 8];
        end

        if ($urandom_range(0, 7) != 0)
            send_item(MODE_START, 8'($urandom), $urandom);
        for (int i = 0; i < REC_OFF; i++) begin
            if ($urandom_range(0, 24) == 0)
                send_aside();
            send_item(MODE_BYTE, hdr[i], $urandom);
        end
        foreach (body[i]) begin
            if ($urandom_range(0, 24) == 0)
                send_aside();
            send_item(MODE_BYTE, body[i], $urandom);
        end
        repeat ($urandom_range(0, 4)) send_item(MODE_BYTE, 8'($urandom), $urandom);
        repeat ($urandom_range(2, 6)) send_item(MODE_QUERY, 8'($urandom), pick_irq());
    endtask

    initial begin
        clear_walker();

        // nothing parsed yet: everything reads zero, a query gives its irq back
        add_row(MODE_NOP,   8'hFF, 32'hFFFF_FFFF, 1, 1'b1, '0);
        add_row(MODE_QUERY, 8'h00, 32'hFFFF_FFFF, 1, 1'b1,
                make_status(32'd0, 5'd0, PH_HEADER, 32'hFFFF_FFFF, 1'b0, 16'h0));
        add_row(MODE_START, 8'hFF, 32'h0000_0000, 1, 1'b1, '0);
        // header: length 0x3c, lapic base all ones
        add_row(MODE_BYTE, 8'h00, 32'h0, 4);
        add_row(MODE_BYTE, 8'h3C, 32'h0, 1);
        add_row(MODE_BYTE, 8'h00, 32'h0, 31);
        add_row(MODE_BYTE, 8'hFF, 32'h0, 4);
        add_row(MODE_BYTE, 8'h00, 32'h0, 4);
        // override irq 5 to gsi ffffffff, flags ffff
        add_row(MODE_BYTE, REC_OVERRIDE, 32'h0, 1);
        add_row(MODE_BYTE, 8'h0A, 32'h0, 1);
        add_row(MODE_BYTE, 8'h00, 32'h0, 1);
        add_row(MODE_BYTE, 8'h05, 32'h0, 1);
        add_row(MODE_BYTE, 8'hFF, 32'h0, 6);
        // io apic record cut to two bytes: its address reads zero
        add_row(MODE_BYTE, REC_IOAPIC, 32'h0, 1);
        add_row(MODE_BYTE, 8'h02, 32'h0, 1);
        // local apic record cut before its flags: not enabled, and the table ends
        add_row(MODE_BYTE, REC_LAPIC, 32'h0, 1);
        add_row(MODE_BYTE, 8'h04, 32'h0, 1);
        add_row(MODE_BYTE, 8'h00, 32'h0, 1);
        add_row(MODE_BYTE, 8'h7F, 32'h0, 1);
        // byte past the end is ignored
        add_row(MODE_BYTE, 8'hFF, 32'h0, 1);
        add_row(MODE_QUERY, 8'h00, 32'd5, 1, 1'b1,
                make_status(32'hFFFF_FFFF, 5'd1, PH_DONE, 32'hFFFF_FFFF, 1'b1, 16'hFFFF));
        // same low byte, but above 255: no match
        add_row(MODE_QUERY, 8'h00, 32'h0000_0105, 1);

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (stim_rows[r]) begin
            repeat (stim_rows[r].reps)
                send_item(stim_rows[r].kind, stim_rows[r].data, stim_rows[r].irq,
                          stim_rows[r].typed, stim_rows[r].want);
        end

        // random part: mostly whole tables, some noise of any kind
        while (live_items < ITEM_TARGET) begin
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(5, 20))
                    send_item(2'($urandom_range(0, 3)), 8'($urandom), $urandom);
            else
                run_table();
        end
        s_tvalid = 1'b0;

        while (pending_status.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("madt_entry_parser regression: pass");
        else
            $display("madt_entry_parser regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/madt_pkg.sv
src/madt_byte_fsm.sv
src/madt_ovr_table.sv
src/madt_entry_parser.sv
src/madt_checker.sv
tb/madt_entry_parser_tb.sv
